### rtl/can_debug_text_reassembler_unit_macros.svh
// Assertion helpers shared by the reassembler modules.
`ifndef CAN_DEBUG_TEXT_REASSEMBLER_UNIT_MACROS_SVH
`define CAN_DEBUG_TEXT_REASSEMBLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CDTR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdtr: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CDTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdtr: next-cycle check failed");

`endif

### rtl/cdtr_pkg.sv
package cdtr_pkg;

   // Fixed geometry of the line buffers.
   localparam int unsigned SOURCES    = 6;
   localparam int unsigned PREFIX_LEN = 3;

   // Identifier classification, applied to the 29-bit identifier.
   localparam logic [28:0] HEARTBEAT_MASK = 29'h1f00601f;
   localparam logic [28:0] DEBUG_MASK     = 29'h1e000000;
   localparam logic [28:0] DEBUG_MATCH    = 29'h1a000000;
   localparam logic [4:0]  CLOSE_SEQUENCE = 5'h1f;

   // Sender codes of the debug frames.
   localparam logic [7:0] SENDER_M1 = 8'hA3;
   localparam logic [7:0] SENDER_M2 = 8'h23;
   localparam logic [7:0] SENDER_A1 = 8'hA5;
   localparam logic [7:0] SENDER_A2 = 8'h25;
   localparam logic [7:0] SENDER_D1 = 8'hA8;

   // Characters and reset values.
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_COLON    = 8'h3a;
   localparam logic [7:0] CHAR_DASH     = 8'h2d;
   localparam logic [7:0] CHAR_M        = 8'h4d;
   localparam logic [7:0] CHAR_A        = 8'h41;
   localparam logic [7:0] CHAR_D        = 8'h44;
   localparam logic [7:0] CHAR_ONE      = 8'h31;
   localparam logic [7:0] CHAR_TWO      = 8'h32;
   localparam logic [7:0] PROGRAM_RESET = 8'hff;
   localparam logic [3:0] DLC_MAX       = 4'd8;

   // Result kinds.
   localparam logic KIND_STATE = 1'b0;
   localparam logic KIND_TEXT  = 1'b1;

   typedef enum logic [2:0] {
      SRC_UNKNOWN = 3'd0,
      SRC_M1      = 3'd1,
      SRC_M2      = 3'd2,
      SRC_A1      = 3'd3,
      SRC_A2      = 3'd4,
      SRC_D1      = 3'd5
   } src_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic latch;
      logic beat;
      logic append_step;
      logic emit_start;
      logic emit_advance;
   } cdtr_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic heartbeat;
      logic debug;
      logic close;
      logic append_done;
      logic emit_last;
   } cdtr_status_type;

   function automatic src_type sender_to_source(input logic [7:0] code);
      src_type src;
      unique case (code)
         SENDER_M1: src = SRC_M1;
         SENDER_M2: src = SRC_M2;
         SENDER_A1: src = SRC_A1;
         SENDER_A2: src = SRC_A2;
         SENDER_D1: src = SRC_D1;
         default:   src = SRC_UNKNOWN;
      endcase
      return src;
   endfunction

   // Two-letter tag of a source; second selects the digit.
   function automatic logic [7:0] tag_char(input src_type src, input logic second);
      logic [7:0] c;
      unique case (src)
         SRC_M1:  c = second ? CHAR_ONE : CHAR_M;
         SRC_M2:  c = second ? CHAR_TWO : CHAR_M;
         SRC_A1:  c = second ? CHAR_ONE : CHAR_A;
         SRC_A2:  c = second ? CHAR_TWO : CHAR_A;
         SRC_D1:  c = second ? CHAR_ONE : CHAR_D;
         default: c = CHAR_DASH;
      endcase
      return c;
   endfunction

endpackage

### rtl/cdtr_ram.sv
module cdtr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 162
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cdtr_ctrl.sv
`include "can_debug_text_reassembler_unit_macros.svh"

module cdtr_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cdtr_pkg::cdtr_status_type status,
   output cdtr_pkg::cdtr_cmd_type    cmd
);
   import cdtr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_BEAT,
      ST_APPEND,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   // State and the two handshake outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_DECODE;
                  req_ready_ff <= 1'b0;
               end
            end
            ST_DECODE: begin
               if (status.heartbeat) begin
                  state_ff     <= ST_BEAT;
                  rsp_valid_ff <= 1'b1;
               end else if (status.debug) begin
                  state_ff <= ST_APPEND;
               end else begin
                  state_ff     <= ST_IDLE;
                  req_ready_ff <= 1'b1;
               end
            end
            ST_BEAT: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            ST_APPEND: begin
               if (status.append_done) begin
                  if (status.close) begin
                     state_ff     <= ST_EMIT;
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff     <= ST_IDLE;
                     req_ready_ff <= 1'b1;
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_ready && status.emit_last) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Commands decoded from the state and the handshakes.
   always_comb begin
      cmd.latch        = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.beat         = (state_ff == ST_DECODE) && status.heartbeat;
      cmd.append_step  = (state_ff == ST_APPEND);
      cmd.emit_start   = (state_ff == ST_APPEND) && status.append_done && status.close;
      cmd.emit_advance = (state_ff == ST_EMIT) && rsp_ready;
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   `CDTR_ASSERT_IMPL(a_ready_excludes_valid, clock, reset, req_ready_ff, !rsp_valid_ff)
   `CDTR_ASSERT_NEXT(a_accept_goes_decode, clock, reset, cmd.latch, state_ff == ST_DECODE)
   `CDTR_ASSERT_IMPL(a_emit_shows_valid, clock, reset, state_ff == ST_EMIT, rsp_valid_ff)

endmodule

### rtl/cdtr_datapath.sv
`include "can_debug_text_reassembler_unit_macros.svh"

module cdtr_datapath #(
   parameter int TEXT_BUFFER_BYTES = 31,
   parameter int LINE_CHARS        = 30,
   parameter int HISTORY_LINES     = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cdtr_pkg::cdtr_cmd_type    cmd,
   output cdtr_pkg::cdtr_status_type status,
   input  logic [31:0]               req_raw_identifier,
   input  logic [3:0]                req_byte_count,
   input  logic [31:0]               req_data_low,
   input  logic [31:0]               req_data_high,
   output logic                      rsp_kind,
   output logic signed [7:0]         rsp_program_state,
   output logic [2:0]                rsp_source,
   output logic [4:0]                rsp_char_position,
   output logic [7:0]                rsp_text_char,
   output logic [2:0]                rsp_history_slot,
   output logic [15:0]               rsp_line_total,
   output logic [15:0]               rsp_frames_received,
   output logic                      rsp_last
);
   import cdtr_pkg::*;

   localparam int STORE_BYTES = TEXT_BUFFER_BYTES - 4;
   localparam int FILL_LIMIT  = TEXT_BUFFER_BYTES - 1;
   localparam int DEPTH       = SOURCES * STORE_BYTES;
   localparam int AW          = $clog2(DEPTH);
   localparam int FW          = $clog2(TEXT_BUFFER_BYTES);
   localparam int PW          = $clog2(LINE_CHARS + 1);
   localparam int CW          = (FW > PW) ? FW : PW;
   localparam int HW          = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;

   logic [15:0]   frame_count_ff;
   logic [15:0]   lines_done_ff;
   logic [HW-1:0] hist_ff;
   logic [HW-1:0] slot_ff;
   logic [7:0]    program_ff;
   logic [FW-1:0] fill_ff [SOURCES];
   logic [3:0]    idx_ff;
   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;

   logic          heartbeat_ff;
   logic          debug_ff;
   logic          close_ff;
   src_type       src_ff;
   logic [3:0]    dlc_ff;
   logic [7:0]    bytes_ff [8];

   logic [28:0]   id;
   logic [FW-1:0] fill_cur;
   logic [AW-1:0] base;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          append_done;
   logic          emit_last;
   logic [7:0]    line_char;

   assign id          = req_raw_identifier[31:3];
   assign fill_cur    = fill_ff[src_ff];
   assign base        = AW'(src_ff) * AW'(STORE_BYTES);
   assign append_done = (idx_ff == dlc_ff);
   assign emit_last   = (pos_ff == PW'(LINE_CHARS - 1));

   // One byte a cycle goes into the store until the buffer limit.
   assign wr_en   = cmd.append_step && !append_done && (fill_cur < FW'(FILL_LIMIT));
   assign wr_addr = base + AW'(fill_cur - FW'(PREFIX_LEN));

   // The read address follows the next position, so the read data matches pos_ff.
   always_comb begin
      priority if (cmd.emit_start) begin
         pos_in = '0;
      end else if (cmd.emit_advance) begin
         pos_in = pos_ff + PW'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_comb begin
      if ((pos_in >= PW'(PREFIX_LEN)) && (CW'(pos_in) < CW'(fill_cur))) begin
         rd_addr = base + AW'(pos_in - PW'(PREFIX_LEN));
      end else begin
         rd_addr = base;
      end
   end

   cdtr_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (bytes_ff[idx_ff[2:0]]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control state: counters, fill counts and positions.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         lines_done_ff  <= '0;
         hist_ff        <= '0;
         program_ff     <= PROGRAM_RESET;
         idx_ff         <= '0;
         pos_ff         <= '0;
         for (int s = 0; s < SOURCES; s++) begin
            fill_ff[s] <= FW'(PREFIX_LEN);
         end
      end else begin
         pos_ff <= pos_in;
         if (cmd.latch) begin
            frame_count_ff <= frame_count_ff + 16'd1;
            idx_ff         <= '0;
         end
         if (cmd.beat) begin
            program_ff <= bytes_ff[1];
         end
         if (cmd.append_step && !append_done) begin
            idx_ff <= idx_ff + 4'd1;
         end
         if (wr_en) begin
            fill_ff[src_ff] <= fill_cur + FW'(1);
         end
         if (cmd.emit_start) begin
            lines_done_ff <= lines_done_ff + 16'd1;
            if (hist_ff == HW'(HISTORY_LINES - 1)) begin
               hist_ff <= '0;
            end else begin
               hist_ff <= hist_ff + HW'(1);
            end
         end
         if (cmd.emit_advance && emit_last) begin
            fill_ff[src_ff] <= FW'(PREFIX_LEN);
         end
      end
   end

   // Frame beat captured at acceptance, and the slot of a closing line.
   always_ff @(posedge clock) begin
      if (reset) begin
         heartbeat_ff <= 1'b0;
         debug_ff     <= 1'b0;
         close_ff     <= 1'b0;
         src_ff       <= SRC_UNKNOWN;
         dlc_ff       <= '0;
         slot_ff      <= '0;
      end else begin
         if (cmd.latch) begin
            heartbeat_ff <= ((id & HEARTBEAT_MASK) == HEARTBEAT_MASK);
            debug_ff     <= ((id & DEBUG_MASK) == DEBUG_MATCH);
            close_ff     <= (id[4:0] == CLOSE_SEQUENCE);
            src_ff       <= sender_to_source(id[15:8]);
            dlc_ff       <= (req_byte_count > DLC_MAX) ? DLC_MAX : req_byte_count;
            for (int b = 0; b < 4; b++) begin
               bytes_ff[b]     <= req_data_low[8*b +: 8];
               bytes_ff[b + 4] <= req_data_high[8*b +: 8];
            end
         end
         if (cmd.emit_start) begin
            slot_ff <= hist_ff;
         end
      end
   end

   // Character at the current line position.
   always_comb begin
      priority if (pos_ff < PW'(2)) begin
         line_char = tag_char(src_ff, pos_ff[0]);
      end else if (pos_ff == PW'(2)) begin
         line_char = CHAR_COLON;
      end else if (CW'(pos_ff) < CW'(fill_cur)) begin
         line_char = rd_data;
      end else begin
         line_char = CHAR_SPACE;
      end
   end

   always_comb begin
      status.heartbeat   = heartbeat_ff;
      status.debug       = debug_ff;
      status.close       = close_ff;
      status.append_done = append_done;
      status.emit_last   = emit_last;
   end

   // Result beat; a heartbeat result zeroes the line fields.
   assign rsp_kind            = heartbeat_ff ? KIND_STATE : KIND_TEXT;
   assign rsp_program_state   = program_ff;
   assign rsp_source          = heartbeat_ff ? 3'd0 : 3'(src_ff);
   assign rsp_char_position   = heartbeat_ff ? 5'd0 : 5'(pos_ff);
   assign rsp_text_char       = heartbeat_ff ? 8'd0 : line_char;
   assign rsp_history_slot    = heartbeat_ff ? 3'd0 : 3'(slot_ff);
   assign rsp_line_total      = lines_done_ff;
   assign rsp_frames_received = frame_count_ff;
   assign rsp_last            = heartbeat_ff || emit_last;

   `CDTR_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, fill_cur <= FW'(FILL_LIMIT))
   `CDTR_ASSERT_IMPL(a_index_bound, clock, reset, cmd.append_step, idx_ff <= dlc_ff)
   `CDTR_ASSERT_NEXT(a_emit_from_zero, clock, reset, cmd.emit_start, pos_ff == '0)

endmodule

### rtl/can_debug_text_reassembler_unit.sv
// Channel   Direction  Ports
// req_      in         raw_identifier, byte_count, data_low, data_high
// rsp_      out        kind, program_state, source, char_position, text_char,
//                      history_slot, line_total, frames_received, last
//
// A frame is taken and decoded; a debug frame is then appended one data byte
// a cycle through the single write port of the text store.
// A closing frame then shows one line character a cycle unless stalled,
// LINE_CHARS beats from the store's registered port; a heartbeat gives one beat.
// Reset is synchronous and active high; fill counts return to the prefix length.
// A stalled result beat holds until taken; no frame is taken while one is worked.
module can_debug_text_reassembler_unit #(
   parameter int TEXT_BUFFER_BYTES = 31,
   parameter int LINE_CHARS        = 30,
   parameter int HISTORY_LINES     = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_raw_identifier,
   input  logic [3:0]         req_byte_count,
   input  logic [31:0]        req_data_low,
   input  logic [31:0]        req_data_high,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic signed [7:0]  rsp_program_state,
   output logic [2:0]         rsp_source,
   output logic [4:0]         rsp_char_position,
   output logic [7:0]         rsp_text_char,
   output logic [2:0]         rsp_history_slot,
   output logic [15:0]        rsp_line_total,
   output logic [15:0]        rsp_frames_received,
   output logic               rsp_last
);
   import cdtr_pkg::*;

   cdtr_cmd_type    cmd;
   cdtr_status_type status;

   // Sequencing of one frame.
   cdtr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Buffers, counters and the result beat.
   cdtr_datapath #(
      .TEXT_BUFFER_BYTES (TEXT_BUFFER_BYTES),
      .LINE_CHARS        (LINE_CHARS),
      .HISTORY_LINES     (HISTORY_LINES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_raw_identifier  (req_raw_identifier),
      .req_byte_count      (req_byte_count),
      .req_data_low        (req_data_low),
      .req_data_high       (req_data_high),
      .rsp_kind            (rsp_kind),
      .rsp_program_state   (rsp_program_state),
      .rsp_source          (rsp_source),
      .rsp_char_position   (rsp_char_position),
      .rsp_text_char       (rsp_text_char),
      .rsp_history_slot    (rsp_history_slot),
      .rsp_line_total      (rsp_line_total),
      .rsp_frames_received (rsp_frames_received),
      .rsp_last            (rsp_last)
   );

endmodule
